// ===== rtl/assert_macros.svh =====
// Assertion macros included by weighted_rr_two_class_queues.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define WRR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define WRR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define WRR_ASSERT(lbl, prop, msg)
`define WRR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/wrr_pkg.sv =====
// Types and constants of the weighted round-robin two-class queues.
package wrr_pkg;

  localparam int unsigned AGE_W    = 7;
  localparam int unsigned PTS_W    = 4;
  localparam int unsigned WGT_W    = 6;
  localparam int unsigned WGTS_W   = 48;
  localparam int unsigned PT_W     = 3;
  localparam int unsigned CID_W    = 16;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CFG_IX_W = 2;

  localparam logic [AGE_W-1:0]  AGE_THR_RST = 7'd60;
  localparam logic [PTS_W-1:0]  ACT_PTS_RST = 4'd8;
  localparam logic [WGTS_W-1:0] WEIGHTS_RST = 48'd4467856773185;

  localparam logic ACT_ENQ   = 1'b0;
  localparam logic ACT_SERVE = 1'b1;

  localparam logic [CFG_IX_W-1:0] REG_AGE_THR = 2'd0;
  localparam logic [CFG_IX_W-1:0] REG_ACT_PTS = 2'd1;
  localparam logic [CFG_IX_W-1:0] REG_WEIGHTS = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK    = 2'd0,
    KIND_SERVED = 2'd1,
    KIND_NONE   = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ACK  = 4'b0010,
    ST_READ = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

endpackage

// ===== rtl/weighted_rr_two_class_queues.sv =====
// Weighted round-robin service of per-point priority and regular customer FIFOs.
// An enqueue beat is accepted with the FIFO write, then the acknowledge beat
// loads the output register; a serve beat that finds no customer is likewise
// acknowledged. A serve beat that finds a point serves each customer with a
// synchronous read of the FIFO memory, then the load of the output register.
// The scan for the next non-empty point is done at accept time from the
// per-point counts. Items are taken one at a time; a new item is accepted
// while the last result still waits in the output register. Configuration is
// to be written only while idle by the user; the block does not enforce it.
`include "assert_macros.svh"

module weighted_rr_two_class_queues #(
  parameter int unsigned NUM_POINTS = 8,
  parameter int unsigned FIFO_DEPTH = 16,
  parameter int unsigned ID_WIDTH   = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wrr_pkg::CFG_IX_W-1:0]      cfg_idx_i,
  input  logic [wrr_pkg::WGTS_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              action_i,
  input  logic [wrr_pkg::PT_W-1:0]          point_i,
  input  logic [wrr_pkg::CID_W-1:0]         customer_id_i,
  input  logic [wrr_pkg::AGE_W-1:0]         age_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [wrr_pkg::KIND_W-1:0]        kind_o,
  output logic                              overflow_o,
  output logic [wrr_pkg::CID_W-1:0]         served_id_o,
  output logic [wrr_pkg::PT_W-1:0]          served_point_o,
  output logic                              from_priority_o,
  output logic                              last_o
);

  localparam int unsigned PIDX = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
  localparam int unsigned HW   = $clog2(FIFO_DEPTH);
  localparam int unsigned CW   = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned CW1  = CW + 1;
  localparam int unsigned SW   = HW + 1;
  localparam int unsigned ENT  = NUM_POINTS * FIFO_DEPTH;
  localparam int unsigned AW   = $clog2(ENT);
  localparam int unsigned NW   = wrr_pkg::PTS_W;
  localparam int unsigned WW   = wrr_pkg::WGT_W;

  // configuration
  logic [wrr_pkg::AGE_W-1:0]  age_thr_q;
  logic [wrr_pkg::PTS_W-1:0]  act_pts_q;
  logic [wrr_pkg::WGTS_W-1:0] weights_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_thr_q <= wrr_pkg::AGE_THR_RST;
      act_pts_q <= wrr_pkg::ACT_PTS_RST;
      weights_q <= wrr_pkg::WEIGHTS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wrr_pkg::REG_AGE_THR: age_thr_q <= cfg_data_i[wrr_pkg::AGE_W-1:0];
        wrr_pkg::REG_ACT_PTS: act_pts_q <= cfg_data_i[wrr_pkg::PTS_W-1:0];
        wrr_pkg::REG_WEIGHTS: weights_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [NW-1:0] num_pts;
  always_comb begin
    if (act_pts_q == '0) num_pts = NW'(1);
    else if (act_pts_q > NW'(NUM_POINTS)) num_pts = NW'(NUM_POINTS);
    else num_pts = act_pts_q;
  end

  // control state
  wrr_pkg::state_e state_q, state_d;
  logic [HW-1:0]   phead_q [NUM_POINTS];
  logic [CW-1:0]   pcnt_q  [NUM_POINTS];
  logic [HW-1:0]   rhead_q [NUM_POINTS];
  logic [CW-1:0]   rcnt_q  [NUM_POINTS];
  logic [PIDX-1:0] turn_q;
  logic [PIDX-1:0] cur_p_q;
  logic [WW-1:0]   rem_q;
  logic            sel_prio_q;
  logic            last_q;
  logic            ack_ovf_q;
  wrr_pkg::kind_e  ack_kind_q;
  logic [wrr_pkg::PT_W-1:0] ack_pt_q;

  // output register
  logic                      out_vld_q;
  wrr_pkg::kind_e            out_kind_q;
  logic                      out_ovf_q;
  logic [wrr_pkg::CID_W-1:0] out_id_q;
  logic [wrr_pkg::PT_W-1:0]  out_pt_q;
  logic                      out_prio_q;
  logic                      out_last_q;

  logic out_free;
  logic acc;
  assign out_free   = !out_vld_q || !out_stall_i;
  assign in_stall_o = (state_q != wrr_pkg::ST_IDLE);
  assign acc        = in_valid_i && (state_q == wrr_pkg::ST_IDLE);

  // enqueue decode
  logic          enq_prio;
  logic          enq_in_range;
  logic [PIDX-1:0] enq_p;
  logic [HW-1:0] enq_head;
  logic [CW-1:0] enq_cnt;
  logic [SW-1:0] tail_sum;
  logic [HW-1:0] tail_idx;
  logic          enq_ok;

  assign enq_prio     = (age_i >= age_thr_q);
  assign enq_in_range = ({1'b0, point_i} < num_pts);
  assign enq_p        = PIDX'(point_i);
  assign enq_head     = enq_prio ? phead_q[enq_p] : rhead_q[enq_p];
  assign enq_cnt      = enq_prio ? pcnt_q[enq_p] : rcnt_q[enq_p];
  assign tail_sum     = SW'(enq_head) + SW'(enq_cnt);
  assign tail_idx     = (tail_sum >= SW'(FIFO_DEPTH)) ? HW'(tail_sum - SW'(FIFO_DEPTH))
                                                      : HW'(tail_sum);
  assign enq_ok       = enq_in_range && (enq_cnt != CW'(FIFO_DEPTH));

  // round-robin scan over non-empty points
  logic [NUM_POINTS-1:0] nonempty;
  logic                  scan_found;
  logic [PIDX-1:0]       scan_p;

  always_comb begin
    logic [NW-1:0] start;
    logic [NW-1:0] idx;
    start      = (NW'(turn_q) < num_pts) ? NW'(turn_q) : '0;
    scan_found = 1'b0;
    scan_p     = '0;
    for (int k = 0; k < NUM_POINTS; k++) begin
      nonempty[k] = (pcnt_q[k] != '0) || (rcnt_q[k] != '0);
    end
    for (int i = 0; i < NUM_POINTS; i++) begin
      idx = start + NW'(i);
      if (idx >= num_pts) idx = idx - num_pts;
      if (!scan_found && (NW'(i) < num_pts) && nonempty[PIDX'(idx)]) begin
        scan_found = 1'b1;
        scan_p     = PIDX'(idx);
      end
    end
  end

  logic [WW-1:0] scan_w;
  logic [NW-1:0] turn_nxt;
  assign scan_w   = weights_q[scan_p*WW +: WW];
  assign turn_nxt = (NW'(scan_p) + NW'(1) == num_pts) ? '0 : NW'(scan_p) + NW'(1);

  // pop decode
  logic [CW-1:0]  cur_pc;
  logic [CW-1:0]  cur_rc;
  logic           pop_prio;
  logic [HW-1:0]  pop_head;
  logic [HW-1:0]  pop_head_nxt;
  logic           pop_last;
  logic [CW1-1:0] cur_tot;

  assign cur_pc       = pcnt_q[cur_p_q];
  assign cur_rc       = rcnt_q[cur_p_q];
  assign pop_prio     = (cur_pc != '0);
  assign pop_head     = pop_prio ? phead_q[cur_p_q] : rhead_q[cur_p_q];
  assign pop_head_nxt = (pop_head == HW'(FIFO_DEPTH - 1)) ? '0 : pop_head + HW'(1);
  assign cur_tot      = CW1'(cur_pc) + CW1'(cur_rc);
  assign pop_last     = (rem_q == WW'(1)) || (cur_tot == CW1'(1));

  logic acc_enq;
  logic acc_srv;
  logic do_pop;
  assign acc_enq = acc && (action_i == wrr_pkg::ACT_ENQ);
  assign acc_srv = acc && (action_i == wrr_pkg::ACT_SERVE);
  assign do_pop  = (state_q == wrr_pkg::ST_READ);

  // FIFO memories
  logic [AW-1:0]       waddr;
  logic [AW-1:0]       raddr;
  logic [ID_WIDTH-1:0] wdata;
  logic                pwe, rwe, pre, rre;
  logic [ID_WIDTH-1:0] pmem [ENT];
  logic [ID_WIDTH-1:0] rmem [ENT];
  logic [ID_WIDTH-1:0] prd_q;
  logic [ID_WIDTH-1:0] rrd_q;

  assign waddr = AW'(enq_p * FIFO_DEPTH) + AW'(tail_idx);
  assign raddr = AW'(cur_p_q * FIFO_DEPTH) + AW'(pop_head);
  assign wdata = ID_WIDTH'(customer_id_i);
  assign pwe   = acc_enq && enq_ok && enq_prio;
  assign rwe   = acc_enq && enq_ok && !enq_prio;
  assign pre   = do_pop && pop_prio;
  assign rre   = do_pop && !pop_prio;

  always_ff @(posedge clk_i) begin
    if (pwe) pmem[waddr] <= wdata;
    if (pre) prd_q <= pmem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rwe) rmem[waddr] <= wdata;
    if (rre) rrd_q <= rmem[raddr];
  end

  // heads and counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_POINTS; k++) begin
        phead_q[k] <= '0;
        pcnt_q[k]  <= '0;
        rhead_q[k] <= '0;
        rcnt_q[k]  <= '0;
      end
    end else begin
      if (pwe) pcnt_q[enq_p] <= enq_cnt + CW'(1);
      if (rwe) rcnt_q[enq_p] <= enq_cnt + CW'(1);
      if (pre) begin
        phead_q[cur_p_q] <= pop_head_nxt;
        pcnt_q[cur_p_q]  <= cur_pc - CW'(1);
      end
      if (rre) begin
        rhead_q[cur_p_q] <= pop_head_nxt;
        rcnt_q[cur_p_q]  <= cur_rc - CW'(1);
      end
    end
  end

  // sequencer
  logic out_load;

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    unique case (state_q)
      wrr_pkg::ST_IDLE: begin
        if (acc_srv && scan_found) state_d = wrr_pkg::ST_READ;
        else if (acc) state_d = wrr_pkg::ST_ACK;
      end
      wrr_pkg::ST_ACK: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = wrr_pkg::ST_IDLE;
        end
      end
      wrr_pkg::ST_READ: begin
        state_d = wrr_pkg::ST_EMIT;
      end
      wrr_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = last_q ? wrr_pkg::ST_IDLE : wrr_pkg::ST_READ;
        end
      end
      default: state_d = wrr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wrr_pkg::ST_IDLE;
      turn_q  <= '0;
    end else begin
      state_q <= state_d;
      if (acc_srv && scan_found) turn_q <= PIDX'(turn_nxt);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      ack_kind_q <= (action_i == wrr_pkg::ACT_ENQ) ? wrr_pkg::KIND_ACK : wrr_pkg::KIND_NONE;
      ack_ovf_q  <= (action_i == wrr_pkg::ACT_ENQ) && !enq_ok;
      ack_pt_q   <= (action_i == wrr_pkg::ACT_ENQ) ? point_i : '0;
      cur_p_q    <= scan_p;
      rem_q      <= (scan_w == '0) ? WW'(1) : scan_w;
    end
    if (do_pop) begin
      sel_prio_q <= pop_prio;
      last_q     <= pop_last;
      rem_q      <= rem_q - WW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (state_q == wrr_pkg::ST_EMIT) begin
        out_kind_q <= wrr_pkg::KIND_SERVED;
        out_ovf_q  <= 1'b0;
        out_id_q   <= wrr_pkg::CID_W'(sel_prio_q ? prd_q : rrd_q);
        out_pt_q   <= wrr_pkg::PT_W'(cur_p_q);
        out_prio_q <= sel_prio_q;
        out_last_q <= last_q;
      end else begin
        out_kind_q <= ack_kind_q;
        out_ovf_q  <= ack_ovf_q;
        out_id_q   <= '0;
        out_pt_q   <= ack_pt_q;
        out_prio_q <= 1'b0;
        out_last_q <= 1'b1;
      end
    end
  end

  assign out_valid_o     = out_vld_q;
  assign kind_o          = out_kind_q;
  assign overflow_o      = out_ovf_q;
  assign served_id_o     = out_id_q;
  assign served_point_o  = out_pt_q;
  assign from_priority_o = out_prio_q;
  assign last_o          = out_last_q;

  // checks
  `WRR_ASSERT(a_pop_nonempty,
              (state_q == wrr_pkg::ST_READ) |-> (cur_tot != '0),
              "pop from empty point")
  `WRR_ASSERT(a_read_to_emit,
              (state_q == wrr_pkg::ST_READ) |=> (state_q == wrr_pkg::ST_EMIT),
              "read not followed by emit")
  `WRR_ASSERT_ALWAYS(a_rem_nonzero,
                     (state_q == wrr_pkg::ST_READ) |-> (rem_q != '0),
                     "turn budget exhausted in read")
  `WRR_ASSERT(a_emit_last_idle,
              (state_q == wrr_pkg::ST_EMIT && out_free && last_q) |=>
                (state_q == wrr_pkg::ST_IDLE && out_last_q),
              "last beat did not end turn")

endmodule
